// ===== sv/prf_pkg.sv =====
package prf_pkg;

	// default sizes of the ring and of one packet
	localparam int unsigned MAX_SLOTS_DEF        = 256;
	localparam int unsigned MAX_PACKET_BYTES_DEF = 8;

	// fixed field widths
	localparam int unsigned OP_W       = 2;
	localparam int unsigned PKT_W      = 64;
	localparam int unsigned COUNT_W    = 9;
	localparam int unsigned QLEN_W     = 9;
	localparam int unsigned PBYTES_W   = 4;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 9;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PACKET_BYTES = 2'd1;

	// register values after reset
	localparam logic [QLEN_W-1:0]   QLEN_RESET   = 9'd256;
	localparam logic [PBYTES_W-1:0] PBYTES_RESET = 4'd8;

	typedef enum logic [OP_W-1:0] {
		OP_GET       = 2'd0,
		OP_PUT_BACK  = 2'd1,
		OP_PUT_FRONT = 2'd2,
		OP_CLEAR     = 2'd3
	} op_t;

	// memory strobes for one accepted word
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// outcome of one accepted word
	typedef struct packed {
		logic success;
		logic is_full;
		logic get_ok;
	} op_status_t;

endpackage

// ===== sv/prf_ifs.sv =====
// command channel: operation and packet
interface prf_cmd_if;
	logic                           valid;
	logic                           ready;
	prf_pkg::op_t                   operation;
	logic [prf_pkg::PKT_W-1:0]      packet_in;

	modport source (output valid, output operation, output packet_in, input ready);
	modport sink   (input valid, input operation, input packet_in, output ready);
endinterface

// result channel: outcome of one operation
interface prf_res_if;
	logic                           valid;
	logic                           ready;
	logic                           success;
	logic [prf_pkg::PKT_W-1:0]      packet_out;
	logic [prf_pkg::COUNT_W-1:0]    packet_count;
	logic                           is_full;

	modport source (output valid, output success, output packet_out, output packet_count,
		output is_full, input ready);
	modport sink   (input valid, input success, input packet_out, input packet_count,
		input is_full, output ready);
endinterface

// ===== sv/prf_slot_mem.sv =====
module prf_slot_mem #(
	parameter int unsigned DEPTH = prf_pkg::MAX_SLOTS_DEF,
	parameter int unsigned AW    = $clog2(prf_pkg::MAX_SLOTS_DEF),
	parameter int unsigned DW    = 8 * prf_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic              clk,
	input  prf_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DW-1:0]     wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [DW-1:0]     rd_data
);
	import prf_pkg::*;

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/prf_ctrl.sv =====
module prf_ctrl #(
	parameter int unsigned MAX_SLOTS        = prf_pkg::MAX_SLOTS_DEF,
	parameter int unsigned MAX_PACKET_BYTES = prf_pkg::MAX_PACKET_BYTES_DEF,
	parameter int unsigned IW               = $clog2(prf_pkg::MAX_SLOTS_DEF),
	parameter int unsigned CW               = $clog2(prf_pkg::MAX_SLOTS_DEF + 1),
	parameter int unsigned DW               = 8 * prf_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [prf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [prf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                accept,
	input  prf_pkg::op_t                        operation,
	input  logic [prf_pkg::PKT_W-1:0]           packet_in,
	output prf_pkg::mem_ctl_t                   mem_ctl,
	output logic [IW-1:0]                       wr_addr,
	output logic [IW-1:0]                       rd_addr,
	output logic [DW-1:0]                       wr_data,
	output prf_pkg::op_status_t                 status,
	output logic [CW-1:0]                       count
);
	import prf_pkg::*;

	logic [QLEN_W-1:0]   qlen_q;
	logic [PBYTES_W-1:0] pbytes_q;
	logic [IW-1:0]       rd_q;
	logic [IW-1:0]       wr_q;
	logic                full_q;

	logic [CW-1:0]       len;
	logic [PBYTES_W-1:0] nbytes;
	logic [IW-1:0]       rd_inc;
	logic [IW-1:0]       rd_dec;
	logic [IW-1:0]       wr_inc;
	logic [IW-1:0]       rd_n;
	logic [IW-1:0]       wr_n;
	logic                full_n;
	logic                empty;
	logic                cfg_hit;

	// effective ring length and packet width
	always_comb begin
		if (qlen_q == '0) begin
			len = CW'(1);
		end else if (32'(qlen_q) > MAX_SLOTS) begin
			len = CW'(MAX_SLOTS);
		end else begin
			len = CW'(qlen_q);
		end
		if (pbytes_q == '0) begin
			nbytes = PBYTES_W'(1);
		end else if (32'(pbytes_q) > MAX_PACKET_BYTES) begin
			nbytes = PBYTES_W'(MAX_PACKET_BYTES);
		end else begin
			nbytes = pbytes_q;
		end
	end

	// bytes above the packet width are stored as zero
	always_comb begin
		for (int i = 0; i < MAX_PACKET_BYTES; i++) begin
			wr_data[8*i +: 8] = (PBYTES_W'(i) < nbytes) ? packet_in[8*i +: 8] : 8'h00;
		end
	end

	// wrapping index steps
	assign rd_inc = (CW'(rd_q) + CW'(1) == len) ? '0 : rd_q + IW'(1);
	assign wr_inc = (CW'(wr_q) + CW'(1) == len) ? '0 : wr_q + IW'(1);
	assign rd_dec = (rd_q == '0) ? IW'(len - CW'(1)) : rd_q - IW'(1);
	assign empty  = !full_q && (rd_q == wr_q);

	// next indices and outcome of the operation
	always_comb begin
		rd_n        = rd_q;
		wr_n        = wr_q;
		full_n      = full_q;
		status      = '0;
		mem_ctl     = '0;
		wr_addr     = wr_q;
		rd_addr     = rd_q;
		unique case (operation)
			OP_GET: begin
				if (!empty) begin
					rd_n           = rd_inc;
					full_n         = 1'b0;
					status.success = 1'b1;
					status.get_ok  = 1'b1;
					mem_ctl.rd_en  = accept;
				end
			end
			OP_PUT_BACK: begin
				if (!full_q) begin
					wr_n           = wr_inc;
					full_n         = (wr_inc == rd_q);
					status.success = 1'b1;
					mem_ctl.wr_en  = accept;
				end
			end
			OP_PUT_FRONT: begin
				if (!full_q) begin
					rd_n           = rd_dec;
					full_n         = (wr_q == rd_dec);
					wr_addr        = rd_dec;
					status.success = 1'b1;
					mem_ctl.wr_en  = accept;
				end
			end
			OP_CLEAR: begin
				rd_n           = '0;
				wr_n           = '0;
				full_n         = 1'b0;
				status.success = 1'b1;
			end
			default: begin
				status = '0;
			end
		endcase
		status.is_full = full_n;
	end

	// packets held after the operation
	always_comb begin
		if (full_n) begin
			count = len;
		end else if (wr_n >= rd_n) begin
			count = CW'(wr_n) - CW'(rd_n);
		end else begin
			count = CW'(wr_n) + len - CW'(rd_n);
		end
	end

	assign cfg_hit = cfg_we && (cfg_index == CFG_QUEUE_LENGTH || cfg_index == CFG_PACKET_BYTES);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q   <= QLEN_RESET;
			pbytes_q <= PBYTES_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_QUEUE_LENGTH) begin
				qlen_q <= cfg_wdata[QLEN_W-1:0];
			end
			if (cfg_index == CFG_PACKET_BYTES) begin
				pbytes_q <= cfg_wdata[PBYTES_W-1:0];
			end
		end
	end

	// ring indices and full flag, emptied by a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			wr_q   <= '0;
			full_q <= 1'b0;
		end else if (cfg_hit) begin
			rd_q   <= '0;
			wr_q   <= '0;
			full_q <= 1'b0;
		end else if (accept) begin
			rd_q   <= rd_n;
			wr_q   <= wr_n;
			full_q <= full_n;
		end
	end

endmodule

// ===== sv/packet_ring_fifo_with_front_insert.sv =====
// channel  dir  handshake        payload
// cmd      in   valid / ready    operation, packet_in
// res      out  valid / ready    success, packet_out, packet_count, is_full
// cfg      in   cfg_we           cfg_index, cfg_wdata (no read-back)
//
// one word per cycle in each direction while res is not stalled; a result appears
// in the cycle after its command word is accepted, with the slot memory read data
// cmd is ready whenever the result register is empty or is being drained
// a stalled result holds its register and stops further command words
// reset empties the ring (queue_length 256, packet_bytes 8); no clearing pass
module packet_ring_fifo_with_front_insert #(
	parameter int unsigned MAX_SLOTS        = prf_pkg::MAX_SLOTS_DEF,
	parameter int unsigned MAX_PACKET_BYTES = prf_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [prf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	prf_cmd_if.sink                        cmd,
	prf_res_if.source                      res
);
	import prf_pkg::*;

	localparam int unsigned IW = $clog2(MAX_SLOTS);
	localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
	localparam int unsigned DW = 8 * MAX_PACKET_BYTES;

	logic          accept;
	mem_ctl_t      mem_ctl;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;
	logic [DW-1:0] wr_data;
	logic [DW-1:0] rd_data;
	op_status_t    status;
	logic [CW-1:0] count;

	logic          res_valid_q;
	op_status_t    status_s1;
	logic [CW-1:0] count_s1;

	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	prf_ctrl #(
		.MAX_SLOTS        (MAX_SLOTS),
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES),
		.IW               (IW),
		.CW               (CW),
		.DW               (DW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.operation (cmd.operation),
		.packet_in (cmd.packet_in),
		.mem_ctl   (mem_ctl),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.wr_data   (wr_data),
		.status    (status),
		.count     (count)
	);

	prf_slot_mem #(
		.DEPTH (MAX_SLOTS),
		.AW    (IW),
		.DW    (DW)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.ready) begin
			res_valid_q <= cmd.valid;
		end
	end

	// result payload, aligned with the memory read data
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			count_s1  <= count;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.success      = status_s1.success;
	assign res.is_full      = status_s1.is_full;
	assign res.packet_count = COUNT_W'(count_s1);
	assign res.packet_out   = status_s1.get_ok ? PKT_W'(rd_data) : '0;

endmodule

// ===== sv/prf_checker.sv =====
module prf_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  prf_pkg::op_t                 cmd_operation,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  logic                         res_success,
	input  logic [prf_pkg::PKT_W-1:0]    res_packet_out,
	input  logic [prf_pkg::COUNT_W-1:0]  res_packet_count,
	input  logic                         res_is_full
);
	import prf_pkg::*;

	// a stalled result word keeps its packet
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_packet_out))
		else $error("stalled result word changed");

	// with no result pending the block takes commands
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("command stalled with empty result register");

	// a full ring never reports zero packets
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_is_full |-> res_packet_count != '0)
		else $error("full flag with zero count");

	// a failed operation returns no packet
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_success |-> res_packet_out == '0)
		else $error("failed operation returned a packet");

	// a clear always succeeds and leaves the ring empty
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_operation == OP_CLEAR |=>
		res_valid && res_success && !res_is_full && res_packet_count == '0)
		else $error("clear left packets behind");

endmodule

bind packet_ring_fifo_with_front_insert prf_checker u_prf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_operation    (cmd.operation),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_success      (res.success),
	.res_packet_out   (res.packet_out),
	.res_packet_count (res.packet_count),
	.res_is_full      (res.is_full)
);
